[sv/arnf_pkg.sv]
// Shared types and constants for the advertising report name filter.
`timescale 1ns / 1ps

package arnf_pkg;

  // Name buffer depth, prefix depth and derived widths
  localparam int NameBytes   = 16;
  localparam int PrefixBytes = 8;
  localparam int NameIdxW    = $clog2(NameBytes);
  localparam int NameLenW    = NameIdxW + 1;

  // Data structure type codes for names
  localparam logic [7:0] TypeNameFull  = 8'h09;
  localparam logic [7:0] TypeNameShort = 8'h08;

  // Configuration register indexes and reset values
  localparam logic [7:0] CfgPrefixValue = 8'd0;
  localparam logic [7:0] CfgPrefixLen   = 8'd1;
  localparam logic [3:0] PrefixLenReset = 4'd6;

  typedef enum logic [1:0] {
    PhLen   = 2'd0,
    PhType  = 2'd1,
    PhValue = 2'd2
  } arnf_phase_e;

  typedef enum logic [1:0] {
    VerdictNotInquiry = 2'd0,
    VerdictNoMatch    = 2'd1,
    VerdictSamePeer   = 2'd2,
    VerdictNewPeer    = 2'd3
  } arnf_verdict_e;

  typedef logic [NameBytes-1:0][7:0] arnf_name_t;

  // Input transaction
  typedef struct packed {
    logic [7:0]         data_byte;
    logic               has_byte;
    logic               report_end;
    logic               is_inquiry;
    logic [47:0]        sender_addr;
    logic signed [7:0]  sender_rssi;
  } arnf_in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]         verdict;
    logic [47:0]        out_addr;
    logic signed [7:0]  out_rssi;
    logic [4:0]         out_name_len;
    logic [63:0]        out_name_low;
    logic [63:0]        out_name_high;
  } arnf_out_t;

  // Parser view after the current byte
  typedef struct packed {
    logic                name_found;
    logic [NameLenW-1:0] cand_len;
    arnf_name_t          cand_name;
  } arnf_view_t;

endpackage

[sv/arnf_parser.sv]
// Length-type-value walker that collects the candidate name of a report.
`timescale 1ns / 1ps

module arnf_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  arnf_pkg::arnf_in_t   item_i,
  output arnf_pkg::arnf_view_t view_o
);

  arnf_pkg::arnf_phase_e              phase_q, phase_d;
  logic [7:0]                         left_q, left_d;
  logic [7:0]                         kind_q, kind_d;
  logic [arnf_pkg::NameLenW-1:0]      len_q, len_d;
  logic                               found_q, found_d;
  logic                               stop_q, stop_d;
  arnf_pkg::arnf_name_t               name_q, name_d;

  function automatic logic is_name(input logic [7:0] k);
    return (k == arnf_pkg::TypeNameFull) || (k == arnf_pkg::TypeNameShort);
  endfunction

  // Advance the parser by one byte
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    kind_d  = kind_q;
    len_d   = len_q;
    found_d = found_q;
    stop_d  = stop_q;
    name_d  = name_q;
    if (item_i.has_byte && !stop_q) begin
      unique case (phase_q)
        arnf_pkg::PhLen: begin
          if (item_i.data_byte == 8'd0) begin
            stop_d = 1'b1;
          end else begin
            left_d  = item_i.data_byte;
            phase_d = arnf_pkg::PhType;
          end
        end
        arnf_pkg::PhType: begin
          kind_d = item_i.data_byte;
          len_d  = '0;
          left_d = left_q - 8'd1;
          if (left_d == 8'd0) begin
            if (is_name(item_i.data_byte)) begin
              found_d = 1'b1;
              stop_d  = 1'b1;
            end else begin
              phase_d = arnf_pkg::PhLen;
            end
          end else begin
            phase_d = arnf_pkg::PhValue;
          end
        end
        arnf_pkg::PhValue: begin
          if (is_name(kind_q) && (len_q < arnf_pkg::NameLenW'(arnf_pkg::NameBytes))) begin
            name_d[len_q[arnf_pkg::NameIdxW-1:0]] = item_i.data_byte;
            len_d = len_q + 1'b1;
          end
          left_d = left_q - 8'd1;
          if (left_d == 8'd0) begin
            if (is_name(kind_q)) begin
              found_d = 1'b1;
              stop_d  = 1'b1;
            end else begin
              phase_d = arnf_pkg::PhLen;
            end
          end
        end
        default: begin
          phase_d = arnf_pkg::PhLen;
        end
      endcase
    end
  end

  assign view_o.name_found = found_d;
  assign view_o.cand_len   = len_d;
  assign view_o.cand_name  = name_d;

  // Hold parser state; clear it after the last transaction of a report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= arnf_pkg::PhLen;
      left_q  <= '0;
      kind_q  <= '0;
      len_q   <= '0;
      found_q <= 1'b0;
      stop_q  <= 1'b0;
    end else if (step_i) begin
      if (item_i.report_end) begin
        phase_q <= arnf_pkg::PhLen;
        left_q  <= '0;
        kind_q  <= '0;
        len_q   <= '0;
        found_q <= 1'b0;
        stop_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        left_q  <= left_d;
        kind_q  <= kind_d;
        len_q   <= len_d;
        found_q <= found_d;
        stop_q  <= stop_d;
      end
    end
  end

  // Candidate name bytes carry no reset
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      name_q <= name_d;
    end
  end

endmodule

[sv/arnf_peer.sv]
// Prefix match, verdict and stored peer record.
`timescale 1ns / 1ps

module arnf_peer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  arnf_pkg::arnf_in_t   item_i,
  input  arnf_pkg::arnf_view_t view_i,
  input  logic [63:0]          prefix_value_i,
  input  logic [3:0]           prefix_len_i,
  output arnf_pkg::arnf_out_t  result_o
);

  logic                          known_q, known_d;
  logic [47:0]                   addr_q, addr_d;
  logic signed [7:0]             rssi_q, rssi_d;
  logic [arnf_pkg::NameLenW-1:0] nlen_q, nlen_d;
  arnf_pkg::arnf_name_t          pname_q, pname_d;

  logic [arnf_pkg::NameLenW-1:0] len;
  logic [3:0]                    need;
  logic                          match;
  arnf_pkg::arnf_verdict_e       verdict;

  // Compare the leading name bytes with the prefix
  always_comb begin
    len  = view_i.name_found ? view_i.cand_len : '0;
    need = (prefix_len_i > 4'(arnf_pkg::PrefixBytes)) ? 4'(arnf_pkg::PrefixBytes)
                                                       : prefix_len_i;
    match = (len >= arnf_pkg::NameLenW'(need));
    for (int i = 0; i < arnf_pkg::PrefixBytes; i++) begin
      if ((4'(i) < need) && (view_i.cand_name[i] != prefix_value_i[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // Decide and record a new peer
  always_comb begin
    known_d = known_q;
    addr_d  = addr_q;
    rssi_d  = rssi_q;
    nlen_d  = nlen_q;
    pname_d = pname_q;
    priority if (!item_i.is_inquiry) begin
      verdict = arnf_pkg::VerdictNotInquiry;
    end else if (!match) begin
      verdict = arnf_pkg::VerdictNoMatch;
    end else if (known_q && (addr_q == item_i.sender_addr)) begin
      verdict = arnf_pkg::VerdictSamePeer;
    end else begin
      verdict = arnf_pkg::VerdictNewPeer;
      known_d = 1'b1;
      addr_d  = item_i.sender_addr;
      rssi_d  = item_i.sender_rssi;
      nlen_d  = len;
      for (int i = 0; i < arnf_pkg::NameBytes; i++) begin
        pname_d[i] = (arnf_pkg::NameLenW'(i) < len) ? view_i.cand_name[i] : 8'd0;
      end
    end
  end

  assign result_o.verdict       = verdict;
  assign result_o.out_addr      = addr_d;
  assign result_o.out_rssi      = rssi_d;
  assign result_o.out_name_len  = nlen_d;
  assign result_o.out_name_low  = pname_d[7:0];
  assign result_o.out_name_high = pname_d[15:8];

  // Hold the peer record; update only at the end of a report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= 1'b0;
      addr_q  <= '0;
      rssi_q  <= '0;
      nlen_q  <= '0;
      pname_q <= '0;
    end else if (step_i && item_i.report_end) begin
      known_q <= known_d;
      addr_q  <= addr_d;
      rssi_q  <= rssi_d;
      nlen_q  <= nlen_d;
      pname_q <= pname_d;
    end
  end

endmodule

[sv/adv_report_name_filter_top.sv]
// Top level of the advertising report name filter.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_data_i   (arnf_in_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o  (arnf_out_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte transaction per cycle unless a report-end transaction is held back;
// the result of a report is loaded into the result register when its
// report-end transaction leaves the input register, and is valid from then on.
// Reset clears the parser, the peer record and sets prefix_len to six.
// A report-end transaction waits in the input register while a result is
// held; other transactions keep flowing through during an output stall.
`timescale 1ns / 1ps

module adv_report_name_filter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  arnf_pkg::arnf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output arnf_pkg::arnf_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  logic [63:0]          prefix_value_q;
  logic [3:0]           prefix_len_q;
  logic                 in_valid_q;
  arnf_pkg::arnf_in_t   in_q;
  logic                 out_valid_q;
  arnf_pkg::arnf_out_t  out_q;
  logic                 out_free;
  logic                 step;
  arnf_pkg::arnf_view_t view;
  arnf_pkg::arnf_out_t  result;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_value_q <= '0;
      prefix_len_q   <= arnf_pkg::PrefixLenReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == arnf_pkg::CfgPrefixValue) begin
        prefix_value_q <= cfg_data_i;
      end else if (cfg_index_i == arnf_pkg::CfgPrefixLen) begin
        prefix_len_q <= cfg_data_i[3:0];
      end
    end
  end

  // Advance the held transaction unless its result has nowhere to go
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && (!in_q.report_end || out_free);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  arnf_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .view_o (view)
  );

  arnf_peer u_peer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_q),
    .view_i         (view),
    .prefix_value_i (prefix_value_q),
    .prefix_len_i   (prefix_len_q),
    .result_o       (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_q.report_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_q.report_end) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the advertising report name filter top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int          CycleLimit   = 300000;
  localparam int          HoldCycles   = 300;
  localparam int          SettleCycles = 6;
  localparam int          PhaseItems   = 70;
  localparam logic [47:0] AddrZero     = 48'h0000_0000_0000;
  localparam logic [47:0] AddrTop      = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] AddrMid      = 48'h5A5A_0F0F_A5A5;

  // One line of the directed stimulus table
  typedef struct {
    bit                  is_cfg;
    arnf_pkg::arnf_in_t  item;
    bit                  typed;
    arnf_pkg::arnf_out_t want;
    logic [7:0]          reg_index;
    logic [63:0]         reg_data;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  arnf_pkg::arnf_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  arnf_pkg::arnf_out_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [7:0]          cfg_index;
  logic [63:0]         cfg_data;

  // Side channel that travels with each transaction: a result typed into the table
  bit                  in_typed;
  arnf_pkg::arnf_out_t in_want;

  // Filter state kept by the testbench
  logic [63:0]           pfx_value;
  logic [3:0]            pfx_len;
  arnf_pkg::arnf_phase_e parse_ph;
  logic [7:0]            left;
  logic [7:0]            kind;
  arnf_pkg::arnf_name_t  cand;
  logic [4:0]            cand_n;
  logic                  found;
  logic                  stopped;
  logic                  known;
  logic [47:0]           peer_addr;
  arnf_pkg::arnf_name_t  rec_name;
  logic [4:0]            peer_len;
  logic signed [7:0]     rec_rssi;

  arnf_pkg::arnf_out_t pending[$];
  plan_row_t           plan[$];
  logic [7:0]          frame[$];
  logic [47:0]         addr_pool[4];

  bit no_idle;
  bit hold_req;
  int cycles;
  int errors;
  int items_sent;
  int results_seen;
  int rand_reports;
  int settings_written;
  int verdict_count[4];

  adv_report_name_filter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 100) $display("cycle %0d: mismatch: %s", cycles, what);
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic arnf_pkg::arnf_in_t make_item(logic has, logic [7:0] b, logic last,
                                                   logic inq, logic [47:0] addr,
                                                   logic signed [7:0] rssi);
    arnf_pkg::arnf_in_t it;
    it = '0;
    it.data_byte   = b;
    it.has_byte    = has;
    it.report_end  = last;
    it.is_inquiry  = inq;
    it.sender_addr = addr;
    it.sender_rssi = rssi;
    return it;
  endfunction

  function automatic arnf_pkg::arnf_out_t make_result(arnf_pkg::arnf_verdict_e v,
                                                      logic [47:0] addr,
                                                      logic signed [7:0] rssi,
                                                      logic [4:0] n,
                                                      logic [63:0] lo, logic [63:0] hi);
    arnf_pkg::arnf_out_t r;
    r.verdict       = v;
    r.out_addr      = addr;
    r.out_rssi      = rssi;
    r.out_name_len  = n;
    r.out_name_low  = lo;
    r.out_name_high = hi;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Name filter predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_name(logic [7:0] k);
    return k == arnf_pkg::TypeNameFull || k == arnf_pkg::TypeNameShort;
  endfunction

  task automatic clear_parser();
    parse_ph = arnf_pkg::PhLen;
    left     = '0;
    kind     = '0;
    cand_n   = '0;
    found    = 1'b0;
    stopped  = 1'b0;
  endtask

  task automatic filter_reset();
    pfx_value = '0;
    pfx_len   = arnf_pkg::PrefixLenReset;
    cand      = '0;
    known     = 1'b0;
    peer_addr = '0;
    rec_name  = '0;
    peer_len  = '0;
    rec_rssi  = '0;
    clear_parser();
  endtask

  // A complete name structure stops the parse; any other one moves on
  task automatic close_field();
    if (is_name(kind)) begin
      found   = 1'b1;
      stopped = 1'b1;
    end else begin
      parse_ph = arnf_pkg::PhLen;
    end
  endtask

  task automatic filter_take(logic [7:0] b);
    if (!stopped) begin
      case (parse_ph)
        arnf_pkg::PhLen: begin
          if (b == 8'd0) begin
            stopped = 1'b1;
          end else begin
            left     = b;
            parse_ph = arnf_pkg::PhType;
          end
        end
        arnf_pkg::PhType: begin
          kind   = b;
          cand_n = '0;
          left   = left - 8'd1;
          if (left == 8'd0) close_field();
          else parse_ph = arnf_pkg::PhValue;
        end
        default: begin
          if (is_name(kind) && cand_n < arnf_pkg::NameBytes) begin
            cand[cand_n[3:0]] = b;
            cand_n = cand_n + 5'd1;
          end
          left = left - 8'd1;
          if (left == 8'd0) close_field();
        end
      endcase
    end
  endtask

  // Work out the verdict of a finished report and queue the result
  task automatic filter_close(arnf_pkg::arnf_in_t it, bit typed,
                              arnf_pkg::arnf_out_t typed_want);
    logic [4:0]              n;
    int                      need;
    int                      i;
    logic                    hit;
    arnf_pkg::arnf_verdict_e v;
    logic [127:0]            flat;
    n    = found ? cand_n : 5'd0;
    need = (pfx_len > arnf_pkg::PrefixBytes) ? arnf_pkg::PrefixBytes : pfx_len;
    hit  = (n >= need);
    for (i = 0; i < need && hit; i++)
      if (cand[i] != pfx_value[8*i +: 8]) hit = 1'b0;
    if (!it.is_inquiry) begin
      v = arnf_pkg::VerdictNotInquiry;
    end else if (!hit) begin
      v = arnf_pkg::VerdictNoMatch;
    end else if (known && peer_addr == it.sender_addr) begin
      v = arnf_pkg::VerdictSamePeer;
    end else begin
      v         = arnf_pkg::VerdictNewPeer;
      peer_addr = it.sender_addr;
      rec_name  = '0;
      for (i = 0; i < n; i++) rec_name[i] = cand[i];
      peer_len  = n;
      rec_rssi  = it.sender_rssi;
      known     = 1'b1;
    end
    verdict_count[v]++;
    flat = rec_name;
    if (typed) pending.push_back(typed_want);
    else pending.push_back(make_result(v, peer_addr, rec_rssi, peer_len,
                                       flat[63:0], flat[127:64]));
    clear_parser();
  endtask

  // Advance the predictor on every accepted input transaction
  always @(posedge clk) begin : input_monitor
    if (rst_n && in_valid && in_ready) begin
      if (in_data.has_byte) filter_take(in_data.data_byte);
      if (in_data.report_end) filter_close(in_data, in_typed, in_want);
    end
  end

  // Track register writes
  always @(posedge clk) begin : cfg_monitor
    if (rst_n && cfg_valid && cfg_ready) begin
      settings_written++;
      if (cfg_index == arnf_pkg::CfgPrefixValue) pfx_value = cfg_data;
      else if (cfg_index == arnf_pkg::CfgPrefixLen) pfx_len = cfg_data[3:0];
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : result_monitor
    arnf_pkg::arnf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result with no report waiting");
      end else begin
        want = pending.pop_front();
        check_field("verdict", out_data.verdict, want.verdict);
        check_field("out_addr", out_data.out_addr, want.out_addr);
        check_field("out_rssi", out_data.out_rssi, want.out_rssi);
        check_field("out_name_len", out_data.out_name_len, want.out_name_len);
        check_field("out_name_low", out_data.out_name_low, want.out_name_low);
        check_field("out_name_high", out_data.out_name_high, want.out_name_high);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (out_valid && out_ready) begin
        stall = no_idle ? 0 : $urandom_range(0, 19);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(arnf_pkg::arnf_in_t it, bit typed = 1'b0,
                           arnf_pkg::arnf_out_t want = '0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    in_typed <= typed;
    in_want  <= want;
    do @(posedge clk); while (!in_ready);
    if (it.has_byte || it.report_end) items_sent++;
  endtask

  // Drop valid and wait until the block has returned every result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic plan_row_t byte_row(logic has, logic [7:0] b, logic last, logic inq,
                                         logic [47:0] addr, logic signed [7:0] rssi);
    plan_row_t r;
    r.is_cfg    = 1'b0;
    r.item      = make_item(has, b, last, inq, addr, rssi);
    r.typed     = 1'b0;
    r.want      = '0;
    r.reg_index = '0;
    r.reg_data  = '0;
    return r;
  endfunction

  function automatic plan_row_t checked(plan_row_t r, arnf_pkg::arnf_out_t want);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [7:0] idx, logic [63:0] data);
    plan_row_t r;
    r           = byte_row(1'b0, 8'h00, 1'b0, 1'b0, AddrZero, 8'sh00);
    r.is_cfg    = 1'b1;
    r.reg_index = idx;
    r.reg_data  = data;
    return r;
  endfunction

  // Directed table; reset prefix is six zero bytes
  task automatic build_plan();
    int i;
    // empty report, not an inquiry, nothing stored yet
    plan.push_back(checked(byte_row(0, 8'hFF, 1, 0, AddrTop, 8'sh80),
                           make_result(arnf_pkg::VerdictNotInquiry, '0, '0, '0, '0, '0)));
    // transaction with no byte and no end: ignored
    plan.push_back(byte_row(0, 8'hFF, 0, 1, AddrTop, 8'sh7F));
    // empty inquiry report: no name, prefix cannot match
    plan.push_back(checked(byte_row(0, 8'h00, 1, 1, AddrZero, 8'sh00),
                           make_result(arnf_pkg::VerdictNoMatch, '0, '0, '0, '0, '0)));
    // zero length stops the parse before an empty name structure
    plan.push_back(byte_row(1, 8'h00, 0, 1, AddrMid, 8'sh10));
    plan.push_back(byte_row(1, 8'h01, 0, 1, AddrMid, 8'sh10));
    plan.push_back(checked(byte_row(1, arnf_pkg::TypeNameFull, 1, 1, AddrMid, 8'sh10),
                           make_result(arnf_pkg::VerdictNoMatch, '0, '0, '0, '0, '0)));
    // shortened name of six zero bytes from the top address: new peer
    plan.push_back(byte_row(1, 8'h07, 0, 1, AddrTop, 8'sh7F));
    plan.push_back(byte_row(1, arnf_pkg::TypeNameShort, 0, 1, AddrTop, 8'sh7F));
    for (i = 0; i < 5; i++) plan.push_back(byte_row(1, 8'h00, 0, 1, AddrTop, 8'sh7F));
    plan.push_back(checked(byte_row(1, 8'h00, 1, 1, AddrTop, 8'sh7F),
                           make_result(arnf_pkg::VerdictNewPeer, AddrTop, 8'sh7F, 5'd6,
                                       '0, '0)));
    // name structure cut off by the end of the report
    plan.push_back(byte_row(1, 8'hFF, 0, 1, AddrMid, 8'sh01));
    plan.push_back(byte_row(1, arnf_pkg::TypeNameFull, 0, 1, AddrMid, 8'sh01));
    plan.push_back(byte_row(1, 8'h41, 0, 1, AddrMid, 8'sh01));
    plan.push_back(byte_row(1, 8'h42, 1, 1, AddrMid, 8'sh01));
    // no prefix required: an empty name matches and clears the stored name
    plan.push_back(reg_row(arnf_pkg::CfgPrefixLen, 64'd0));
    plan.push_back(byte_row(1, 8'h01, 0, 1, AddrZero, 8'sh80));
    plan.push_back(byte_row(1, arnf_pkg::TypeNameFull, 1, 1, AddrZero, 8'sh80));
    // same sender again, no name at all
    plan.push_back(byte_row(1, 8'h02, 0, 1, AddrZero, 8'sh05));
    plan.push_back(byte_row(1, 8'hFF, 0, 1, AddrZero, 8'sh05));
    plan.push_back(byte_row(1, 8'h80, 1, 1, AddrZero, 8'sh05));
    plan.push_back(reg_row(arnf_pkg::CfgPrefixValue, '1));
    plan.push_back(reg_row(arnf_pkg::CfgPrefixLen, 64'd8));
  endtask

  // ---------------------------------------------------------------------------
  // Random reports
  // ---------------------------------------------------------------------------

  function automatic logic [47:0] pick_addr();
    logic [63:0] r;
    r = rand64();
    if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, 3)];
    return r[47:0];
  endfunction

  // Append a structure of a type other than a name
  task automatic add_other();
    int          n;
    logic [7:0]  t;
    n = $urandom_range(1, 8);
    do t = 8'($urandom_range(0, 255)); while (is_name(t));
    frame.push_back(8'(n));
    frame.push_back(t);
    repeat (n - 1) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  // Append a name structure, usually starting with the current prefix
  task automatic add_name();
    int   nlen;
    int   need;
    int   i;
    int   at;
    logic keep;
    nlen = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
    need = (pfx_len > arnf_pkg::PrefixBytes) ? arnf_pkg::PrefixBytes : pfx_len;
    keep = ($urandom_range(0, 4) != 0);
    frame.push_back(8'(nlen + 1));
    frame.push_back($urandom_range(0, 1) ? arnf_pkg::TypeNameFull : arnf_pkg::TypeNameShort);
    for (i = 0; i < nlen; i++)
      frame.push_back((keep && i < need) ? pfx_value[8*i +: 8] : 8'($urandom_range(0, 255)));
    // now and then spoil one prefix byte
    if (keep && need > 0 && nlen > 0 && $urandom_range(0, 9) == 0) begin
      at = frame.size() - nlen + $urandom_range(0, ((need < nlen) ? need : nlen) - 1);
      frame[at] = frame[at] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  task automatic random_report();
    int                shape;
    int                cut;
    int                k;
    int                n;
    logic              inq;
    logic              bare_end;
    logic [47:0]       addr;
    logic signed [7:0] rssi;
    logic [7:0]        t;
    frame.delete();
    shape    = $urandom_range(0, 99);
    inq      = ($urandom_range(0, 9) != 0);
    addr     = pick_addr();
    rssi     = 8'($urandom_range(0, 255));
    bare_end = ($urandom_range(0, 9) == 0);
    if (shape < 60) begin
      // well-formed report
      repeat ($urandom_range(0, 2)) add_other();
      add_name();
      if ($urandom_range(0, 3) == 0) add_other();
    end else if (shape < 72) begin
      // report cut inside a structure
      repeat ($urandom_range(0, 1)) add_other();
      add_name();
      cut = $urandom_range(1, frame.size() - 1);
      while (frame.size() > cut) frame.delete(frame.size() - 1);
    end else if (shape < 82) begin
      // zero length ahead of the name
      repeat ($urandom_range(0, 1)) add_other();
      frame.push_back(8'h00);
      add_name();
    end else if (shape < 94) begin
      repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom_range(0, 255)));
    end else if (shape < 98) begin
      bare_end = 1'b1;
    end else begin
      // one long structure before the name
      n = $urandom_range(200, 255);
      do t = 8'($urandom_range(0, 255)); while (is_name(t));
      frame.push_back(8'(n));
      frame.push_back(t);
      repeat (n - 1) frame.push_back(8'($urandom_range(0, 255)));
      add_name();
    end
    if (frame.size() == 0) bare_end = 1'b1;
    for (k = 0; k < frame.size(); k++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(make_item(0, 8'($urandom_range(0, 255)), 0, inq, addr, rssi));
      send_item(make_item(1, frame[k], !bare_end && k == frame.size() - 1, inq, addr, rssi));
    end
    if (bare_end) send_item(make_item(0, 8'($urandom_range(0, 255)), 1, inq, addr, rssi));
    rand_reports++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int          k;
    int          phase_no;
    int          start;
    int          base;
    logic [3:0]  len_plan[8];
    logic [63:0] value;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    in_typed  = 1'b0;
    in_want   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    len_plan  = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd12, 4'd6, 4'd1, 4'd5};
    filter_reset();
    addr_pool[0] = AddrZero;
    addr_pool[1] = AddrTop;
    value = rand64();
    addr_pool[2] = value[47:0];
    value = rand64();
    addr_pool[3] = value[47:0];
    build_plan();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cfg) begin
        settle();
        write_reg(plan[k].reg_index, plan[k].reg_data);
      end else begin
        send_item(plan[k].item, plan[k].typed, plan[k].want);
      end
    end

    // random phases, each with its own prefix setting
    base     = items_sent;
    phase_no = 0;
    while (items_sent - base < 550 || rand_reports < 40) begin
      settle();
      case (phase_no % 5)
        1:       value = '1;
        3:       value = '0;
        default: value = rand64();
      endcase
      write_reg(arnf_pkg::CfgPrefixLen, {60'd0, len_plan[phase_no % 8]});
      write_reg(arnf_pkg::CfgPrefixValue, value);
      no_idle = (phase_no % 3 == 1) || (phase_no == 2);
      if (phase_no == 2) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PhaseItems) random_report();
      phase_no++;
    end
    no_idle = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (pending.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending.size()));

    $display("run: %0d byte transactions, %0d results, %0d register writes",
             items_sent, results_seen, settings_written);
    $display("verdicts: not inquiry %0d, no match %0d, same peer %0d, new peer %0d",
             verdict_count[arnf_pkg::VerdictNotInquiry],
             verdict_count[arnf_pkg::VerdictNoMatch],
             verdict_count[arnf_pkg::VerdictSamePeer],
             verdict_count[arnf_pkg::VerdictNewPeer]);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
